@@ sv/roi_pkg.sv @@
// types, codes and tableau selection shared by the rossler integrator modules
`timescale 1ns / 1ps

package roi_pkg;

  localparam int unsigned STEP_BITS  = 32;
  localparam int unsigned DT_BITS    = 25;
  localparam int unsigned STAGE_BITS = 3;
  localparam int unsigned COMP_BITS  = 2;
  localparam int unsigned SLOT_BITS  = 5;
  localparam int unsigned SLOT_DEPTH = 18;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [1:0] {
    M_EULER,
    M_HEUN3,
    M_RK4,
    M_DOPRI5
  } method_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_METHOD,
    CFG_TIME_STEP,
    CFG_COEF_A,
    CFG_COEF_B,
    CFG_COEF_C,
    CFG_STEP_LIMIT
  } cfg_idx_e;

  typedef enum logic [4:0] {
    WT_ZERO,
    WT_ONE,
    WT_HALF,
    WT_THIRD,
    WT_TWO_THIRDS,
    WT_QUARTER,
    WT_THREE_QUARTERS,
    WT_SIXTH,
    WT_A21,
    WT_A31,
    WT_A32,
    WT_A41,
    WT_A42,
    WT_A43,
    WT_A51,
    WT_A52,
    WT_A53,
    WT_A54,
    WT_A61,
    WT_A62,
    WT_A63,
    WT_A64,
    WT_A65,
    WT_B1,
    WT_B3,
    WT_B4,
    WT_B5,
    WT_B6
  } weight_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_INIT,
    OP_D0,
    OP_EMIT,
    OP_EMIT_FIN,
    OP_EMIT_UPD
  } dp_op_e;

  typedef enum logic [1:0] {
    MA_WEIGHT,
    MA_COEF_A,
    MA_T2,
    MA_DT
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_SLOPE,
    MB_T1,
    MB_E,
    MB_D
  } mul_b_e;

  typedef enum logic [1:0] {
    WB_MAC,
    WB_D1,
    WB_D2,
    WB_K
  } wb_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_EMIT,
    ST_HALT_EMIT,
    ST_INIT,
    ST_SCAN,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_WAIT,
    ST_D0,
    ST_D1_MUL,
    ST_D1_WAIT,
    ST_D2_MUL,
    ST_D2_WAIT,
    ST_K_MUL,
    ST_K_WAIT,
    ST_STEP_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e                op;
    logic                  mul_start;
    mul_a_e                a_sel;
    mul_b_e                b_sel;
    wb_e                   wb;
    logic [COMP_BITS-1:0]  comp;
    logic [SLOT_BITS-1:0]  slot;
    weight_e               wt;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic finished;
  } dp_status_t;

  function automatic logic [STAGE_BITS-1:0] stage_count(input method_e m);
    logic [STAGE_BITS-1:0] n;
    unique case (m)
      M_EULER:  n = 3'd1;
      M_HEUN3:  n = 3'd3;
      M_RK4:    n = 3'd4;
      M_DOPRI5: n = 3'd6;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  // tableau entry for stage s and slope j, or the final weights when fin_sum is set
  function automatic weight_e weight_sel(input method_e m, input logic fin_sum,
                                         input logic [STAGE_BITS-1:0] s,
                                         input logic [STAGE_BITS-1:0] j);
    weight_e w;
    w = WT_ZERO;
    if (fin_sum) begin
      unique case (m)
        M_EULER: begin
          if (j == 3'd0) w = WT_ONE;
        end
        M_HEUN3: begin
          if (j == 3'd0) w = WT_QUARTER;
          if (j == 3'd2) w = WT_THREE_QUARTERS;
        end
        M_RK4: begin
          if (j == 3'd0 || j == 3'd3) w = WT_SIXTH;
          if (j == 3'd1 || j == 3'd2) w = WT_THIRD;
        end
        M_DOPRI5: begin
          if (j == 3'd0) w = WT_B1;
          if (j == 3'd2) w = WT_B3;
          if (j == 3'd3) w = WT_B4;
          if (j == 3'd4) w = WT_B5;
          if (j == 3'd5) w = WT_B6;
        end
        default: w = WT_ZERO;
      endcase
    end else begin
      unique case (m)
        M_EULER: w = WT_ZERO;
        M_HEUN3: begin
          if (s == 3'd1 && j == 3'd0) w = WT_THIRD;
          if (s == 3'd2 && j == 3'd1) w = WT_TWO_THIRDS;
        end
        M_RK4: begin
          if (s == 3'd1 && j == 3'd0) w = WT_HALF;
          if (s == 3'd2 && j == 3'd1) w = WT_HALF;
          if (s == 3'd3 && j == 3'd2) w = WT_ONE;
        end
        M_DOPRI5: begin
          if (s == 3'd1 && j == 3'd0) w = WT_A21;
          if (s == 3'd2 && j == 3'd0) w = WT_A31;
          if (s == 3'd2 && j == 3'd1) w = WT_A32;
          if (s == 3'd3 && j == 3'd0) w = WT_A41;
          if (s == 3'd3 && j == 3'd1) w = WT_A42;
          if (s == 3'd3 && j == 3'd2) w = WT_A43;
          if (s == 3'd4 && j == 3'd0) w = WT_A51;
          if (s == 3'd4 && j == 3'd1) w = WT_A52;
          if (s == 3'd4 && j == 3'd2) w = WT_A53;
          if (s == 3'd4 && j == 3'd3) w = WT_A54;
          if (s == 3'd5 && j == 3'd0) w = WT_A61;
          if (s == 3'd5 && j == 3'd1) w = WT_A62;
          if (s == 3'd5 && j == 3'd2) w = WT_A63;
          if (s == 3'd5 && j == 3'd3) w = WT_A64;
          if (s == 3'd5 && j == 3'd4) w = WT_A65;
        end
        default: w = WT_ZERO;
      endcase
    end
    return w;
  endfunction

endpackage

@@ sv/roi_mul.sv @@
// multi-cycle signed fixed-point multiplier with rounding and saturation
`timescale 1ns / 1ps

module roi_mul #(
  parameter int unsigned WORD_BITS = 40,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] res_o,
  output logic                        clip_o
);

  localparam int unsigned H  = (WORD_BITS + 1) / 2;
  localparam int unsigned MW = 2 * H;
  localparam int unsigned AW = 4 * H;
  localparam int unsigned PW = AW + 1;

  logic [MW-1:0]         ua_q, ub_q;
  logic                  neg_q;
  logic [AW-1:0]         acc_q;
  logic [2:0]            ph_q;
  logic                  busy_q, done_q;
  logic signed [WORD_BITS-1:0] res_q;
  logic                  clip_q;

  logic [H-1:0]          aa, bb;
  logic [MW-1:0]         pp;
  logic [AW-1:0]         pp_sh;
  logic [PW-1:0]         sum, q, lim;
  logic signed [WORD_BITS-1:0] rnd_val;
  logic                  rnd_clip;
  logic [WORD_BITS-1:0]  mag_a, mag_b;

  assign mag_a = a_i[WORD_BITS-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[WORD_BITS-1] ? (~b_i + 1'b1) : b_i;

  always_comb begin
    aa = ph_q[1] ? ua_q[MW-1:H] : ua_q[H-1:0];
    bb = ph_q[0] ? ub_q[MW-1:H] : ub_q[H-1:0];
    pp = MW'(aa) * MW'(bb);
    unique case ({ph_q[1], ph_q[0]})
      2'b00:   pp_sh = AW'(pp);
      2'b01:   pp_sh = AW'(pp) << H;
      2'b10:   pp_sh = AW'(pp) << H;
      2'b11:   pp_sh = AW'(pp) << (2 * H);
      default: pp_sh = AW'(pp);
    endcase
  end

  always_comb begin
    sum = {1'b0, acc_q} + (PW'(1) << (FRAC_BITS - 1));
    q   = sum >> FRAC_BITS;
    lim = PW'(1) << (WORD_BITS - 1);
    rnd_clip = 1'b0;
    if (neg_q) begin
      if (q > lim) begin
        rnd_clip = 1'b1;
        rnd_val  = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
        rnd_val = ~q[WORD_BITS-1:0] + 1'b1;
      end
    end else begin
      if (q >= lim) begin
        rnd_clip = 1'b1;
        rnd_val  = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else begin
        rnd_val = q[WORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= 3'd0;
      end else if (busy_q) begin
        if (ph_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          ph_q <= ph_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= MW'(mag_a);
      ub_q  <= MW'(mag_b);
      neg_q <= a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1];
      acc_q <= '0;
    end else if (busy_q) begin
      if (ph_q == 3'd4) begin
        res_q  <= rnd_val;
        clip_q <= rnd_clip;
      end else begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

@@ sv/roi_datapath.sv @@
// datapath: state, stage values, slope memory, shared multiplier and result register
`timescale 1ns / 1ps

module roi_datapath
  import roi_pkg::*;
#(
  parameter int unsigned WORD_BITS = 40,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dp_cmd_t                     cmd_i,
  output dp_status_t                  status_o,
  input  logic [DT_BITS-1:0]          time_step_i,
  input  logic signed [WORD_BITS-1:0] coef_a_i,
  input  logic signed [WORD_BITS-1:0] coef_b_i,
  input  logic signed [WORD_BITS-1:0] coef_c_i,
  input  logic [STEP_BITS-1:0]        step_limit_i,
  input  logic signed [WORD_BITS-1:0] load_x_i,
  input  logic signed [WORD_BITS-1:0] load_y_i,
  input  logic signed [WORD_BITS-1:0] load_z_i,
  output logic signed [WORD_BITS-1:0] out_x_o,
  output logic signed [WORD_BITS-1:0] out_y_o,
  output logic signed [WORD_BITS-1:0] out_z_o,
  output logic [STEP_BITS-1:0]        step_index_o,
  output logic                        finished_o,
  output logic                        saturated_o
);

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  localparam logic [63:0] Q_1_2  = ((64'd1 << FRAC_BITS) + 64'd1) / 64'd2;
  localparam logic [63:0] Q_1_3  = ((64'd1 << FRAC_BITS) + 64'd1) / 64'd3;
  localparam logic [63:0] Q_2_3  = ((64'd2 << FRAC_BITS) + 64'd1) / 64'd3;
  localparam logic [63:0] Q_1_4  = ((64'd1 << FRAC_BITS) + 64'd2) / 64'd4;
  localparam logic [63:0] Q_3_4  = ((64'd3 << FRAC_BITS) + 64'd2) / 64'd4;
  localparam logic [63:0] Q_1_6  = ((64'd1 << FRAC_BITS) + 64'd3) / 64'd6;
  localparam logic [63:0] Q_A21  = ((64'd1 << FRAC_BITS) + 64'd2) / 64'd5;
  localparam logic [63:0] Q_A31  = ((64'd3 << FRAC_BITS) + 64'd20) / 64'd40;
  localparam logic [63:0] Q_A32  = ((64'd9 << FRAC_BITS) + 64'd20) / 64'd40;
  localparam logic [63:0] Q_A41  = ((64'd44 << FRAC_BITS) + 64'd22) / 64'd45;
  localparam logic [63:0] Q_A42  = 64'd0 - (((64'd56 << FRAC_BITS) + 64'd7) / 64'd15);
  localparam logic [63:0] Q_A43  = ((64'd32 << FRAC_BITS) + 64'd4) / 64'd9;
  localparam logic [63:0] Q_A51  = ((64'd19372 << FRAC_BITS) + 64'd3280) / 64'd6561;
  localparam logic [63:0] Q_A52  = 64'd0 - (((64'd25360 << FRAC_BITS) + 64'd1093) / 64'd2187);
  localparam logic [63:0] Q_A53  = ((64'd64448 << FRAC_BITS) + 64'd3280) / 64'd6561;
  localparam logic [63:0] Q_A54  = 64'd0 - (((64'd212 << FRAC_BITS) + 64'd364) / 64'd729);
  localparam logic [63:0] Q_A61  = ((64'd9017 << FRAC_BITS) + 64'd1584) / 64'd3168;
  localparam logic [63:0] Q_A62  = 64'd0 - (((64'd355 << FRAC_BITS) + 64'd16) / 64'd33);
  localparam logic [63:0] Q_A63  = ((64'd46732 << FRAC_BITS) + 64'd2623) / 64'd5247;
  localparam logic [63:0] Q_A64  = ((64'd49 << FRAC_BITS) + 64'd88) / 64'd176;
  localparam logic [63:0] Q_A65  = 64'd0 - (((64'd5103 << FRAC_BITS) + 64'd9328) / 64'd18656);
  localparam logic [63:0] Q_B1   = ((64'd35 << FRAC_BITS) + 64'd192) / 64'd384;
  localparam logic [63:0] Q_B3   = ((64'd500 << FRAC_BITS) + 64'd556) / 64'd1113;
  localparam logic [63:0] Q_B4   = ((64'd125 << FRAC_BITS) + 64'd96) / 64'd192;
  localparam logic [63:0] Q_B5   = 64'd0 - (((64'd2187 << FRAC_BITS) + 64'd3392) / 64'd6784);
  localparam logic [63:0] Q_B6   = ((64'd11 << FRAC_BITS) + 64'd42) / 64'd84;

  localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  function automatic logic [WORD_BITS-1:0] weight_value(input weight_e w);
    logic [63:0] v;
    unique case (w)
      WT_ZERO:           v = 64'd0;
      WT_ONE:            v = ONE;
      WT_HALF:           v = Q_1_2;
      WT_THIRD:          v = Q_1_3;
      WT_TWO_THIRDS:     v = Q_2_3;
      WT_QUARTER:        v = Q_1_4;
      WT_THREE_QUARTERS: v = Q_3_4;
      WT_SIXTH:          v = Q_1_6;
      WT_A21:            v = Q_A21;
      WT_A31:            v = Q_A31;
      WT_A32:            v = Q_A32;
      WT_A41:            v = Q_A41;
      WT_A42:            v = Q_A42;
      WT_A43:            v = Q_A43;
      WT_A51:            v = Q_A51;
      WT_A52:            v = Q_A52;
      WT_A53:            v = Q_A53;
      WT_A54:            v = Q_A54;
      WT_A61:            v = Q_A61;
      WT_A62:            v = Q_A62;
      WT_A63:            v = Q_A63;
      WT_A64:            v = Q_A64;
      WT_A65:            v = Q_A65;
      WT_B1:             v = Q_B1;
      WT_B3:             v = Q_B3;
      WT_B4:             v = Q_B4;
      WT_B5:             v = Q_B5;
      WT_B6:             v = Q_B6;
      default:           v = 64'd0;
    endcase
    return v[WORD_BITS-1:0];
  endfunction

  // result in the low bits, clip flag on top
  function automatic logic [WORD_BITS:0] sat_add(input logic signed [WORD_BITS-1:0] a,
                                                 input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return {1'b1, (s[WORD_BITS] ? W_MIN : W_MAX)};
    end
    return {1'b0, s[WORD_BITS-1:0]};
  endfunction

  function automatic logic [WORD_BITS:0] sat_sub(input logic signed [WORD_BITS-1:0] a,
                                                 input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return {1'b1, (s[WORD_BITS] ? W_MIN : W_MAX)};
    end
    return {1'b0, s[WORD_BITS-1:0]};
  endfunction

  logic signed [WORD_BITS-1:0] pos_q [3];
  logic signed [WORD_BITS-1:0] t_q   [3];
  logic signed [WORD_BITS-1:0] d_q   [3];
  logic signed [WORD_BITS-1:0] e_q;
  logic [STEP_BITS-1:0]        steps_q;
  logic                        clipped_q;
  logic signed [WORD_BITS-1:0] slope_mem [SLOT_DEPTH];
  logic signed [WORD_BITS-1:0] rd_q;
  wb_e                         pend_wb_q;
  logic [COMP_BITS-1:0]        pend_comp_q;
  logic [SLOT_BITS-1:0]        pend_slot_q;

  logic signed [WORD_BITS-1:0] out_x_q, out_y_q, out_z_q;
  logic [STEP_BITS-1:0]        out_idx_q;
  logic                        out_fin_q, out_sat_q;

  logic signed [WORD_BITS-1:0] mul_a, mul_b, mul_res;
  logic                        mul_done, mul_clip;
  logic [WORD_BITS-1:0]        dt_ext;
  logic [WORD_BITS:0]          wb_r, d0a_r, d0_r, e_r;

  assign dt_ext = WORD_BITS'(time_step_i);

  always_comb begin
    unique case (cmd_i.a_sel)
      MA_WEIGHT: mul_a = weight_value(cmd_i.wt);
      MA_COEF_A: mul_a = coef_a_i;
      MA_T2:     mul_a = t_q[2];
      MA_DT:     mul_a = dt_ext;
      default:   mul_a = '0;
    endcase
    unique case (cmd_i.b_sel)
      MB_SLOPE: mul_b = rd_q;
      MB_T1:    mul_b = t_q[1];
      MB_E:     mul_b = e_q;
      MB_D:     mul_b = d_q[cmd_i.comp];
      default:  mul_b = '0;
    endcase
  end

  roi_mul #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res),
    .clip_o  (mul_clip)
  );

  always_comb begin
    unique case (pend_wb_q)
      WB_MAC:  wb_r = sat_add(t_q[pend_comp_q], mul_res);
      WB_D1:   wb_r = sat_add(t_q[0], mul_res);
      WB_D2:   wb_r = sat_add(coef_b_i, mul_res);
      WB_K:    wb_r = {1'b0, mul_res};
      default: wb_r = {1'b0, mul_res};
    endcase
    d0a_r = sat_sub('0, t_q[1]);
    d0_r  = sat_sub(d0a_r[WORD_BITS-1:0], t_q[2]);
    e_r   = sat_sub(t_q[0], coef_c_i);
  end

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0]  <= '0;
      pos_q[1]  <= '0;
      pos_q[2]  <= '0;
      steps_q   <= '0;
      clipped_q <= 1'b0;
    end else begin
      if (mul_done) begin
        clipped_q <= clipped_q | mul_clip | wb_r[WORD_BITS];
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          pos_q[0]  <= load_x_i;
          pos_q[1]  <= load_y_i;
          pos_q[2]  <= load_z_i;
          steps_q   <= '0;
          clipped_q <= 1'b0;
        end
        OP_START: clipped_q <= 1'b0;
        OP_D0:    clipped_q <= clipped_q | d0a_r[WORD_BITS] | d0_r[WORD_BITS] | e_r[WORD_BITS];
        OP_EMIT_UPD: begin
          pos_q[0] <= t_q[0];
          pos_q[1] <= t_q[1];
          pos_q[2] <= t_q[2];
          steps_q  <= steps_q + 1'b1;
        end
        OP_NONE, OP_INIT, OP_EMIT, OP_EMIT_FIN: ;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      pend_wb_q   <= cmd_i.wb;
      pend_comp_q <= cmd_i.comp;
      pend_slot_q <= cmd_i.slot;
    end
    if (mul_done) begin
      unique case (pend_wb_q)
        WB_MAC:  t_q[pend_comp_q] <= wb_r[WORD_BITS-1:0];
        WB_D1:   d_q[1] <= wb_r[WORD_BITS-1:0];
        WB_D2:   d_q[2] <= wb_r[WORD_BITS-1:0];
        WB_K:    ;
        default: ;
      endcase
    end
    unique case (cmd_i.op)
      OP_INIT: begin
        t_q[0] <= pos_q[0];
        t_q[1] <= pos_q[1];
        t_q[2] <= pos_q[2];
      end
      OP_D0: begin
        d_q[0] <= d0_r[WORD_BITS-1:0];
        e_q    <= e_r[WORD_BITS-1:0];
      end
      OP_EMIT, OP_EMIT_FIN, OP_EMIT_UPD: begin
        out_x_q   <= pos_q[0];
        out_y_q   <= pos_q[1];
        out_z_q   <= pos_q[2];
        out_idx_q <= steps_q;
        out_fin_q <= (cmd_i.op == OP_EMIT_FIN);
        out_sat_q <= clipped_q;
      end
      OP_NONE, OP_LOAD, OP_START: ;
      default: ;
    endcase
  end

  // slope memory, registered read
  always_ff @(posedge clk_i) begin
    if (mul_done && pend_wb_q == WB_K) begin
      slope_mem[pend_slot_q] <= mul_res;
    end
    rd_q <= slope_mem[cmd_i.slot];
  end

  assign status_o.mul_done = mul_done;
  assign status_o.finished = (steps_q >= step_limit_i);

  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_z_o      = out_z_q;
  assign step_index_o = out_idx_q;
  assign finished_o   = out_fin_q;
  assign saturated_o  = out_sat_q;

endmodule

@@ sv/roi_ctrl.sv @@
// controller: sequences stages, weighted sums and slope evaluations over the datapath
`timescale 1ns / 1ps

module roi_ctrl
  import roi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  method_e    method_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e           state_q, state_d;
  logic [STAGE_BITS-1:0] stage_q, stage_d;
  logic [STAGE_BITS-1:0] j_q, j_d;
  logic [COMP_BITS-1:0]  comp_q, comp_d;
  logic                  fin_q, fin_d;
  logic                  out_valid_q, out_valid_d;

  logic [STAGE_BITS-1:0] n_stages, j_lim;
  logic                  out_free, emit;
  weight_e               cur_wt;
  logic [SLOT_BITS-1:0]  mac_slot, k_slot;

  assign n_stages = stage_count(method_i);
  assign j_lim    = fin_q ? n_stages : stage_q;
  assign cur_wt   = weight_sel(method_i, fin_q, stage_q, j_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign mac_slot = (SLOT_BITS'(j_q) << 1) + SLOT_BITS'(j_q) + SLOT_BITS'(comp_q);
  assign k_slot   = (SLOT_BITS'(stage_q) << 1) + SLOT_BITS'(stage_q) + SLOT_BITS'(comp_q);

  // next state
  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    j_d     = j_q;
    comp_d  = comp_q;
    fin_d   = fin_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i) begin
            state_d = ST_LOAD_EMIT;
          end else if (status_i.finished) begin
            state_d = ST_HALT_EMIT;
          end else begin
            state_d = ST_INIT;
            stage_d = '0;
            fin_d   = 1'b0;
          end
        end
      end
      ST_LOAD_EMIT, ST_HALT_EMIT, ST_STEP_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_INIT: begin
        comp_d  = '0;
        j_d     = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (j_q >= j_lim) begin
          j_d = '0;
          if (comp_q == 2'd2) begin
            comp_d  = '0;
            state_d = fin_q ? ST_STEP_EMIT : ST_D0;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else if (cur_wt != WT_ZERO) begin
          state_d = ST_MAC_RD;
        end else begin
          j_d = j_q + 3'd1;
        end
      end
      ST_MAC_RD:  state_d = ST_MAC_MUL;
      ST_MAC_MUL: state_d = ST_MAC_WAIT;
      ST_MAC_WAIT: begin
        if (status_i.mul_done) begin
          j_d     = j_q + 3'd1;
          state_d = ST_SCAN;
        end
      end
      ST_D0:     state_d = ST_D1_MUL;
      ST_D1_MUL: state_d = ST_D1_WAIT;
      ST_D1_WAIT: begin
        if (status_i.mul_done) state_d = ST_D2_MUL;
      end
      ST_D2_MUL: state_d = ST_D2_WAIT;
      ST_D2_WAIT: begin
        if (status_i.mul_done) begin
          comp_d  = '0;
          state_d = ST_K_MUL;
        end
      end
      ST_K_MUL: state_d = ST_K_WAIT;
      ST_K_WAIT: begin
        if (status_i.mul_done) begin
          if (comp_q == 2'd2) begin
            if (stage_q + 3'd1 == n_stages) begin
              fin_d = 1'b1;
            end else begin
              stage_d = stage_q + 3'd1;
            end
            state_d = ST_INIT;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = ST_K_MUL;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_NONE;
    cmd_o.a_sel     = MA_WEIGHT;
    cmd_o.b_sel     = MB_SLOPE;
    cmd_o.wb        = WB_MAC;
    cmd_o.wt        = WT_ZERO;
    cmd_o.comp      = comp_q;
    cmd_o.slot      = mac_slot;
    emit            = 1'b0;
    in_stall_o      = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) cmd_o.op = command_i ? OP_LOAD : OP_START;
      end
      ST_LOAD_EMIT: begin
        if (out_free) begin
          cmd_o.op = OP_EMIT;
          emit     = 1'b1;
        end
      end
      ST_HALT_EMIT: begin
        if (out_free) begin
          cmd_o.op = OP_EMIT_FIN;
          emit     = 1'b1;
        end
      end
      ST_STEP_EMIT: begin
        if (out_free) begin
          cmd_o.op = OP_EMIT_UPD;
          emit     = 1'b1;
        end
      end
      ST_INIT: cmd_o.op = OP_INIT;
      ST_MAC_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.a_sel     = MA_WEIGHT;
        cmd_o.wt        = cur_wt;
        cmd_o.b_sel     = MB_SLOPE;
        cmd_o.wb        = WB_MAC;
      end
      ST_D0: cmd_o.op = OP_D0;
      ST_D1_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.a_sel     = MA_COEF_A;
        cmd_o.b_sel     = MB_T1;
        cmd_o.wb        = WB_D1;
      end
      ST_D2_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.a_sel     = MA_T2;
        cmd_o.b_sel     = MB_E;
        cmd_o.wb        = WB_D2;
      end
      ST_K_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.a_sel     = MA_DT;
        cmd_o.b_sel     = MB_D;
        cmd_o.wb        = WB_K;
        cmd_o.slot      = k_slot;
      end
      ST_SCAN, ST_MAC_RD, ST_MAC_WAIT, ST_D1_WAIT, ST_D2_WAIT, ST_K_WAIT: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= '0;
      j_q         <= '0;
      comp_q      <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      j_q         <= j_d;
      comp_q      <= comp_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_valid_q) |-> !out_stall_i)
    else $error("result written while previous item still stalled");

  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_LOAD_EMIT && state_q != ST_HALT_EMIT) |->
      (stage_q < n_stages))
    else $error("stage counter beyond stage count");

  a_mul_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_start |=> (state_q == ST_MAC_WAIT || state_q == ST_D1_WAIT ||
                         state_q == ST_D2_WAIT || state_q == ST_K_WAIT))
    else $error("multiplier started outside a product sequence");
`endif

endmodule

@@ sv/rossler_ode_integrator_unit.sv @@
// top level: configuration registers, controller and datapath of the rossler integrator
//
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    command_i, load_x_i, load_y_i, load_z_i
// out       output     out_valid_o / out_stall_i  out_x_o, out_y_o, out_z_o, step_index_o,
//                                                 finished_o, saturated_o
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// a step item runs euler, heun, rk4 or dormand-prince through the one shared multiplier:
// each stage forms its weighted sum over the earlier slopes with a nonzero weight, then
// evaluates the slope; the final sum adds every slope with a nonzero weight, then emits
// reset clears state, step count and configuration registers to their defaults; no clearing pass
// a new item is taken while the previous result waits; a finished result waits for stall low
`timescale 1ns / 1ps

module rossler_ode_integrator_unit
  import roi_pkg::*;
#(
  parameter int unsigned WORD_BITS = 40,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [((WORD_BITS > 32) ? WORD_BITS : 32)-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic signed [WORD_BITS-1:0] load_x_i,
  input  logic signed [WORD_BITS-1:0] load_y_i,
  input  logic signed [WORD_BITS-1:0] load_z_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORD_BITS-1:0] out_x_o,
  output logic signed [WORD_BITS-1:0] out_y_o,
  output logic signed [WORD_BITS-1:0] out_z_o,
  output logic [STEP_BITS-1:0]        step_index_o,
  output logic                        finished_o,
  output logic                        saturated_o
);

  localparam logic [63:0] RST_DT    = ((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000;
  localparam logic [63:0] RST_COEF  = ((64'd1 << FRAC_BITS) + 64'd2) / 64'd5;
  localparam logic [63:0] RST_C     = ((64'd57 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [STEP_BITS-1:0] RST_LIMIT = 32'd300000;

  method_e                     method_q;
  logic [DT_BITS-1:0]          dt_q;
  logic signed [WORD_BITS-1:0] coef_a_q, coef_b_q, coef_c_q;
  logic [STEP_BITS-1:0]        limit_q;

  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= M_RK4;
      dt_q     <= RST_DT[DT_BITS-1:0];
      coef_a_q <= RST_COEF[WORD_BITS-1:0];
      coef_b_q <= RST_COEF[WORD_BITS-1:0];
      coef_c_q <= RST_C[WORD_BITS-1:0];
      limit_q  <= RST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_METHOD:     method_q <= method_e'(cfg_data_i[1:0]);
        CFG_TIME_STEP:  dt_q     <= cfg_data_i[DT_BITS-1:0];
        CFG_COEF_A:     coef_a_q <= cfg_data_i[WORD_BITS-1:0];
        CFG_COEF_B:     coef_b_q <= cfg_data_i[WORD_BITS-1:0];
        CFG_COEF_C:     coef_c_q <= cfg_data_i[WORD_BITS-1:0];
        CFG_STEP_LIMIT: limit_q  <= cfg_data_i[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  roi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .method_i    (method_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  roi_datapath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .time_step_i  (dt_q),
    .coef_a_i     (coef_a_q),
    .coef_b_i     (coef_b_q),
    .coef_c_i     (coef_c_q),
    .step_limit_i (limit_q),
    .load_x_i     (load_x_i),
    .load_y_i     (load_y_i),
    .load_z_i     (load_z_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .step_index_o (step_index_o),
    .finished_o   (finished_o),
    .saturated_o  (saturated_o)
  );

endmodule

@@ tb/tb_rossler_ode_integrator_unit.sv @@
// testbench for the rossler integrator: directed and random items checked against a local predictor
`timescale 1ns / 1ps

module tb_rossler_ode_integrator_unit;
  import roi_pkg::*;

  localparam longint WMAX = (64'sd1 <<< 39) - 1;
  localparam longint WMIN = -WMAX - 1;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam int PHASE_ITEMS = 350;

  typedef struct {
    logic signed [39:0] x;
    logic signed [39:0] y;
    logic signed [39:0] z;
    logic [31:0]        idx;
    logic               fin;
    logic               sat;
  } state_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [39:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = 1'b0;
  logic signed [39:0] load_x_i = '0;
  logic signed [39:0] load_y_i = '0;
  logic signed [39:0] load_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [39:0] out_x_o, out_y_o, out_z_o;
  logic [31:0] step_index_o;
  logic finished_o, saturated_o;

  rossler_ode_integrator_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .command_i, .load_x_i, .load_y_i, .load_z_i,
    .out_valid_o, .out_stall_i, .out_x_o, .out_y_o, .out_z_o,
    .step_index_o, .finished_o, .saturated_o
  );

  // predictor state
  method_e     mdl_method;
  longint      mdl_dt, mdl_a, mdl_b, mdl_c;
  longint      mdl_limit, mdl_steps;
  longint      pos[3];
  longint      slope[6][3];
  longint      wt_a[4][6][6];
  longint      wt_b[4][6];
  int          n_stages[4];
  bit          clip;

  state_out_t  expected_q[$];
  int          err_cnt = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  longint      cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint qc(longint n, longint d);
    return ((n <<< 24) + d / 2) / d;
  endfunction

  function automatic void build_tableau();
    foreach (wt_a[m, s, j]) wt_a[m][s][j] = 0;
    foreach (wt_b[m, j]) wt_b[m][j] = 0;
    n_stages = '{1, 3, 4, 6};
    wt_a[1][1][0] = qc(1, 3);  wt_a[1][2][1] = qc(2, 3);
    wt_a[2][1][0] = qc(1, 2);  wt_a[2][2][1] = qc(1, 2);  wt_a[2][3][2] = qc(1, 1);
    wt_a[3][1][0] = qc(1, 5);
    wt_a[3][2][0] = qc(3, 40);  wt_a[3][2][1] = qc(9, 40);
    wt_a[3][3][0] = qc(44, 45); wt_a[3][3][1] = -qc(56, 15); wt_a[3][3][2] = qc(32, 9);
    wt_a[3][4][0] = qc(19372, 6561);  wt_a[3][4][1] = -qc(25360, 2187);
    wt_a[3][4][2] = qc(64448, 6561);  wt_a[3][4][3] = -qc(212, 729);
    wt_a[3][5][0] = qc(9017, 3168);   wt_a[3][5][1] = -qc(355, 33);
    wt_a[3][5][2] = qc(46732, 5247);  wt_a[3][5][3] = qc(49, 176);
    wt_a[3][5][4] = -qc(5103, 18656);
    wt_b[0][0] = qc(1, 1);
    wt_b[1][0] = qc(1, 4);  wt_b[1][2] = qc(3, 4);
    wt_b[2][0] = qc(1, 6);  wt_b[2][1] = qc(1, 3); wt_b[2][2] = qc(1, 3); wt_b[2][3] = qc(1, 6);
    wt_b[3][0] = qc(35, 384);  wt_b[3][2] = qc(500, 1113); wt_b[3][3] = qc(125, 192);
    wt_b[3][4] = -qc(2187, 6784); wt_b[3][5] = qc(11, 84);
  endfunction

  function automatic longint clamp(longint v);
    if (v > WMAX) begin
      clip = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      clip = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [63:0]  ua, ub;
    logic [127:0] p;
    bit           neg;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << 23)) >> 24;
    if (neg) begin
      if (p > (128'd1 << 39)) begin
        clip = 1'b1;
        return WMIN;
      end
      return -longint'(p[63:0]);
    end
    if (p > 128'(WMAX)) begin
      clip = 1'b1;
      return WMAX;
    end
    return longint'(p[63:0]);
  endfunction

  function automatic void eval_slope(longint p[3], int s);
    longint d[3];
    d[0] = clamp(clamp(0 - p[1]) - p[2]);
    d[1] = clamp(p[0] + qmul(mdl_a, p[1]));
    d[2] = clamp(mdl_b + qmul(p[2], clamp(p[0] - mdl_c)));
    for (int i = 0; i < 3; i++) slope[s][i] = qmul(mdl_dt, d[i]);
  endfunction

  function automatic state_out_t integrate(bit cmd, longint lx, longint ly, longint lz);
    state_out_t r;
    longint     tmp[3];
    int         m, n;
    clip = 1'b0;
    if (cmd) begin
      pos[0] = lx; pos[1] = ly; pos[2] = lz;
      mdl_steps = 0;
    end
    r.x = pos[0]; r.y = pos[1]; r.z = pos[2];
    r.idx = mdl_steps[31:0];
    r.fin = 1'b0;
    r.sat = 1'b0;
    if (cmd) return r;
    if (mdl_steps >= mdl_limit) begin
      r.fin = 1'b1;
      return r;
    end
    m = int'(mdl_method);
    n = n_stages[m];
    for (int s = 0; s < n; s++) begin
      for (int i = 0; i < 3; i++) begin
        tmp[i] = pos[i];
        for (int j = 0; j < s; j++)
          if (wt_a[m][s][j] != 0) tmp[i] = clamp(tmp[i] + qmul(wt_a[m][s][j], slope[j][i]));
      end
      eval_slope(tmp, s);
    end
    for (int i = 0; i < 3; i++) begin
      tmp[i] = pos[i];
      for (int j = 0; j < n; j++)
        if (wt_b[m][j] != 0) tmp[i] = clamp(tmp[i] + qmul(wt_b[m][j], slope[j][i]));
    end
    for (int i = 0; i < 3; i++) pos[i] = tmp[i];
    mdl_steps++;
    r.sat = clip;
    return r;
  endfunction

  function automatic logic [39:0] rand40();
    return 40'({$urandom(), $urandom()});
  endfunction

  task automatic send_item(bit cmd, logic signed [39:0] lx = '0, logic signed [39:0] ly = '0,
                           logic signed [39:0] lz = '0);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    load_x_i <= lx;
    load_y_i <= ly;
    load_z_i <= lz;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(integrate(cmd, lx, ly, lz));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [39:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_METHOD:     mdl_method = method_e'(val[1:0]);
      CFG_TIME_STEP:  mdl_dt = longint'(val[24:0]);
      CFG_COEF_A:     mdl_a = longint'(signed'(val));
      CFG_COEF_B:     mdl_b = longint'(signed'(val));
      CFG_COEF_C:     mdl_c = longint'(signed'(val));
      CFG_STEP_LIMIT: mdl_limit = longint'(val[31:0]);
      default: ;
    endcase
  endtask

  task automatic test_load_extremes();
    send_item(1'b0);
    send_item(1'b1, 40'(WMAX), 40'(WMIN), '0);
    send_item(1'b1, 40'(WMIN), 40'(WMAX), '1);
    send_item(1'b1, 40'sd16777216, -40'sd16777216, 40'sd3355443);
    send_item(1'b0);
  endtask

  task automatic test_methods();
    for (int m = 0; m < 4; m++) begin
      drain();
      write_reg(CFG_METHOD, 40'(m));
      send_item(1'b1, 40'sd16777216, 40'sd16777216, 40'sd16777216);
      send_item(1'b0);
      send_item(1'b0);
    end
  endtask

  task automatic test_step_limit();
    drain();
    write_reg(CFG_STEP_LIMIT, 40'd1);
    send_item(1'b1, 40'sd1000, -40'sd1000, 40'sd5);
    send_item(1'b0);
    send_item(1'b0);
    drain();
    write_reg(CFG_STEP_LIMIT, 40'd0);
    send_item(1'b0);
    drain();
    write_reg(CFG_STEP_LIMIT, 40'hFF_FFFF_FFFF);
  endtask

  task automatic test_saturation();
    drain();
    write_reg(CFG_COEF_A, 40'(WMAX));
    write_reg(CFG_COEF_B, 40'(WMIN));
    write_reg(CFG_COEF_C, 40'(WMIN));
    write_reg(CFG_TIME_STEP, 40'h1FF_FFFF);
    write_reg(CFG_METHOD, 40'(M_DOPRI5));
    send_item(1'b1, 40'(WMAX), 40'(WMAX), 40'(WMIN));
    send_item(1'b0);
    drain();
    write_reg(CFG_TIME_STEP, 40'd0);
    send_item(1'b0);
    drain();
    write_reg(CFG_TIME_STEP, 40'd16777216);
    write_reg(CFG_COEF_A, 40'sd3355443);
    write_reg(CFG_COEF_B, 40'sd3355443);
    write_reg(CFG_COEF_C, 40'sd95630131);
    send_item(1'b1, 40'sd16777216, '0, '0);
    send_item(1'b0);
  endtask

  task automatic test_random(int gap, int stall);
    int items;
    items = 0;
    gap_pct = gap;
    stall_pct = stall;
    while (items < PHASE_ITEMS) begin
      drain();
      write_reg(CFG_METHOD, 40'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: write_reg(CFG_TIME_STEP, 40'($urandom_range(0, 1) ? 0 : 16777216));
          1: write_reg(CFG_TIME_STEP, 40'($urandom()));
          default: write_reg(CFG_TIME_STEP, 40'($urandom_range(0, 1 << 21)));
        endcase
        if ($urandom_range(0, 4) == 0) begin
          write_reg(CFG_COEF_A, rand40());
          write_reg(CFG_COEF_B, rand40());
          write_reg(CFG_COEF_C, rand40());
        end else begin
          write_reg(CFG_COEF_A, 40'($signed($urandom_range(0, 1 << 25)) - (1 << 24)));
          write_reg(CFG_COEF_B, 40'($signed($urandom_range(0, 1 << 25)) - (1 << 24)));
          write_reg(CFG_COEF_C, 40'($urandom_range(0, 200000000)));
        end
        write_reg(CFG_STEP_LIMIT, 40'($urandom_range(0, 3) == 0 ?
                                     $urandom_range(0, 12) : $urandom()));
      end
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 4) == 0)
          send_item(1'b1, rand40(), rand40(), rand40());
        else
          send_item(1'b1, 40'($signed($urandom_range(0, 1 << 29)) - (1 << 28)),
                    40'($signed($urandom_range(0, 1 << 29)) - (1 << 28)),
                    40'($signed($urandom_range(0, 1 << 29)) - (1 << 28)));
        items++;
      end
      repeat ($urandom_range(1, 20)) begin
        send_item(1'b0);
        items++;
      end
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    state_out_t e;
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    if (out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no expected item pending");
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (out_x_o !== e.x) begin
          $error("out_x: expected %0d, got %0d", e.x, out_x_o); err_cnt++;
        end
        if (out_y_o !== e.y) begin
          $error("out_y: expected %0d, got %0d", e.y, out_y_o); err_cnt++;
        end
        if (out_z_o !== e.z) begin
          $error("out_z: expected %0d, got %0d", e.z, out_z_o); err_cnt++;
        end
        if (step_index_o !== e.idx) begin
          $error("step_index: expected %0d, got %0d", e.idx, step_index_o); err_cnt++;
        end
        if (finished_o !== e.fin) begin
          $error("finished: expected %0d, got %0d", e.fin, finished_o); err_cnt++;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated: expected %0d, got %0d", e.sat, saturated_o); err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    build_tableau();
    mdl_method = M_RK4;
    mdl_dt = 16777;
    mdl_a = 3355443;
    mdl_b = 3355443;
    mdl_c = 95630131;
    mdl_limit = 300000;
    mdl_steps = 0;
    pos = '{0, 0, 0};
    gap_pct = 12;
    stall_pct = 74;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_extremes();
    test_methods();
    test_step_limit();
    test_saturation();
    test_random(12, 74);
    test_random(74, 12);
    test_random(0, 0);
    drain();
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/roi_pkg.sv
sv/roi_mul.sv
sv/roi_datapath.sv
sv/roi_ctrl.sv
sv/rossler_ode_integrator_unit.sv
tb/tb_rossler_ode_integrator_unit.sv
